>>> hw/rtl/loudness_gain_window_control_assert.svh
// Assertion macros shared by the loudness gain window control modules
`ifndef LOUDNESS_GAIN_WINDOW_CONTROL_ASSERT_SVH
`define LOUDNESS_GAIN_WINDOW_CONTROL_ASSERT_SVH

// Check a condition at every clock edge outside reset
`define LGWC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a consequence in the same cycle
`define LGWC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the following cycle
`define LGWC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/lgwc_pkg.sv
// Types and constants of the loudness gain window control
package lgwc_pkg;

    localparam int TIME_W     = 32;
    localparam int LEVEL_W    = 16;
    localparam int SLOT_W     = 7;
    localparam int DIV_W      = 7;
    localparam int THR_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int RING_DEPTH = 80;
    localparam int REM_W      = 15;
    localparam int SUM_W      = 23;
    localparam int BND_W      = 25;

    // 20000 = 625 << 5: reduce time >> 5 mod 625, then append the low five bits
    localparam int TLO_W      = 5;
    localparam int THI_W      = TIME_W - TLO_W;
    localparam int Q625_W     = 18;
    localparam int R625_W     = 10;
    localparam int RCP625_W   = 28;
    localparam int RCP625_SH  = 37;
    localparam int QPROD_W    = THI_W + RCP625_W;
    // slot = (rem >> 1) / 125
    localparam int RCP125_W   = 15;
    localparam int RCP125_SH  = 21;
    localparam int SPROD_W    = REM_W - 1 + RCP125_W;

    localparam logic [CFG_IDX_W-1:0] REG_DEC_THR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INC_THR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_THR   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIV_START = 2'd3;

    localparam logic signed [THR_W-1:0] DEC_THR_RESET = 16'sd100;
    localparam logic signed [THR_W-1:0] INC_THR_RESET = 16'sd1000;
    localparam logic signed [THR_W-1:0] OFF_THR_RESET = 16'sd20;

    localparam logic [DIV_W-1:0] DIV_MIN   = 7'd20;
    localparam logic [DIV_W-1:0] DIV_MAX   = 7'd120;
    localparam logic [DIV_W-1:0] DIV_RESET = 7'd60;

    localparam logic [SLOT_W-1:0] LAST_SLOT_RESET = 7'd50;
    localparam logic [SLOT_W-1:0] LAST_SLOT_INDEX = 7'd79;

    localparam logic [REM_W-1:0]    MOD_PERIOD = 15'd20000;
    localparam logic [RCP625_W-1:0] RCP625     = 28'd219902326;
    localparam logic [R625_W-1:0]   DIV625     = 10'd625;
    localparam logic [RCP125_W-1:0] RCP125     = 15'd16778;

    localparam logic [SLOT_W-1:0] MOD_LAST = 7'd1;
    localparam logic [SLOT_W-1:0] QUO_LAST = 7'd0;

    localparam logic [SLOT_W-1:0] WIN_INC     = 7'd8;
    localparam logic [SLOT_W-1:0] WIN_OFF_CLR = 7'd32;
    localparam logic [SLOT_W-1:0] WIN_DEC     = 7'd40;
    localparam logic [SLOT_W-1:0] WIN_OFF_SET = 7'd80;
    localparam logic [SLOT_W-1:0] WIN_NONE    = 7'd0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD,
        ST_QUO,
        ST_CMP,
        ST_SWEEP,
        ST_DRAIN,
        ST_DEC,
        ST_INC,
        ST_OFF_SET,
        ST_OFF_CLR,
        ST_FIN
    } lgwc_state_t;

    typedef struct packed {
        logic load_in;
        logic mod_step;
        logic quo_step;
        logic slot_cmp;
        logic rd_issue;
        logic dec_chk;
        logic inc_chk;
        logic off_set_chk;
        logic off_clr_chk;
        logic out_load;
    } lgwc_cmd_t;

    typedef struct packed {
        logic              fresh;
        logic              slot_zero;
        logic              slot_mod20;
        logic              slot_mod8;
        logic [SLOT_W-1:0] sweep_len;
        logic              out_busy;
    } lgwc_sts_t;

endpackage

>>> hw/rtl/lgwc_if.sv
// Handshake channels for level samples and control results
interface lgwc_in_if;
    import lgwc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [TIME_W-1:0]         time_ms;
    logic signed [LEVEL_W-1:0] level;

    modport source (output valid, output time_ms, output level, input ready);
    modport sink (input valid, input time_ms, input level, output ready);
endinterface

interface lgwc_out_if;
    import lgwc_pkg::*;

    logic              valid;
    logic              ready;
    logic              new_slot;
    logic [SLOT_W-1:0] slot_index;
    logic [DIV_W-1:0]  divider;
    logic              is_off;

    modport source (output valid, output new_slot, output slot_index, output divider,
                    output is_off, input ready);
    modport sink (input valid, input new_slot, input slot_index, input divider,
                  input is_off, output ready);
endinterface

>>> hw/rtl/loudness_gain_window_control.sv
// Top level of the loudness gain window control
// Each sample transfer maps its millisecond time to one of 80 quarter-second slots and,
// on a new slot, stores the level in an 80-entry ring (cleared at reset through per-entry
// valid bits, so no clearing pass) and updates the divider and off flag from windowed
// averages. One sample is processed at a time. The slot is found in order: time mod 20000
// in two steps (a reciprocal multiply gives (time >> 5) / 625, then the remainder is
// formed), one reciprocal multiply for the division by 250 and one slot compare. New slots
// that are multiples of 8 or 20 then sweep the ring through its single read port, one entry
// per cycle (32 reads, 40 at slots 20, 40 and 60, 80 at slot 0), followed by a drain state
// and one state per applicable check. A finished result waits in an output register, so
// the next sample transfer is taken while it is pending; a second result stalls until the
// first one transfers.
module loudness_gain_window_control (
    input  logic                              clk,
    input  logic                              rst_n,
    lgwc_in_if.sink                           sample,
    lgwc_out_if.source                        result,
    input  logic                              cfg_we,
    input  logic [lgwc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lgwc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import lgwc_pkg::*;

    lgwc_cmd_t cmd;
    lgwc_sts_t sts;

    lgwc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_ready (sample.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lgwc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .time_ms   (sample.time_ms),
        .level     (sample.level),
        .cmd       (cmd),
        .sts       (sts),
        .result    (result)
    );

endmodule

>>> hw/rtl/lgwc_datapath.sv
// Datapath: slot arithmetic, level ring, window sums, divider and off state
`include "loudness_gain_window_control_assert.svh"

module lgwc_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [lgwc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lgwc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic [lgwc_pkg::TIME_W-1:0]          time_ms,
    input  logic signed [lgwc_pkg::LEVEL_W-1:0]  level,
    input  lgwc_pkg::lgwc_cmd_t                  cmd,
    output lgwc_pkg::lgwc_sts_t                  sts,
    lgwc_out_if.source                           result
);
    import lgwc_pkg::*;

    logic signed [THR_W-1:0]   dec_thr_reg;
    logic signed [THR_W-1:0]   inc_thr_reg;
    logic signed [THR_W-1:0]   off_thr_reg;
    logic [DIV_W-1:0]          div_reg;
    logic                      off_reg;
    logic [SLOT_W-1:0]         last_reg;
    logic [RING_DEPTH-1:0]     vld_reg;
    logic                      rd_pend_reg;
    logic                      out_vld_reg;

    logic [TIME_W-1:0]         time_reg;
    logic signed [LEVEL_W-1:0] level_reg;
    logic [Q625_W-1:0]         q625_reg;
    logic [REM_W-1:0]          rem_reg;
    logic [SLOT_W-1:0]         quo_reg;
    logic                      fresh_reg;
    logic [SLOT_W-1:0]         addr_reg;
    logic signed [LEVEL_W-1:0] rd_data_reg;
    logic                      rd_vld_reg;
    logic signed [SUM_W-1:0]   acc_reg;
    logic [SLOT_W-1:0]         acc_cnt_reg;
    logic signed [SUM_W-1:0]   s8_reg;
    logic signed [SUM_W-1:0]   s32_reg;
    logic signed [SUM_W-1:0]   s40_reg;
    logic                      out_new_reg;
    logic [SLOT_W-1:0]         out_slot_reg;
    logic [DIV_W-1:0]          out_div_reg;
    logic                      out_off_reg;

    logic signed [LEVEL_W-1:0] ring_mem [RING_DEPTH];

    logic [QPROD_W-1:0]        q_prod;
    logic [Q625_W-1:0]         q625_next;
    logic [THI_W-1:0]          r625_full;
    logic [REM_W-1:0]          rem_next;
    logic [SPROD_W-1:0]        s_prod;
    logic [SLOT_W-1:0]         quo_next;
    logic                      slot_fresh;
    logic                      slot_zero;
    logic                      slot_mod20;
    logic                      slot_mod8;
    logic [SLOT_W-1:0]         addr_dec;
    logic signed [LEVEL_W-1:0] acc_entry;
    logic signed [SUM_W-1:0]   acc_sum;
    logic [SLOT_W-1:0]         acc_cnt_inc;
    logic                      dec_hit;
    logic                      inc_hit;
    logic                      off_hit;
    logic                      on_hit;
    logic [DIV_W-1:0]          div_start;

    // trunc(sum / n) <= thr, worked out as a bound on the sum
    function automatic logic avg_at_most(input logic signed [SUM_W-1:0] sum,
                                         input logic signed [THR_W-1:0] thr,
                                         input logic [SLOT_W-1:0] n);
        logic signed [BND_W-1:0] n_s;
        logic signed [BND_W-1:0] bnd;
        n_s = BND_W'($signed({1'b0, n}));
        bnd = BND_W'(thr) * n_s;
        if (!sum[SUM_W-1])
        begin
            bnd = bnd + n_s - BND_W'(1);
        end
        return BND_W'(sum) <= bnd;
    endfunction

    always_comb
    begin
        q_prod      = QPROD_W'(time_reg[TIME_W-1:TLO_W]) * QPROD_W'(RCP625);
        q625_next   = q_prod[RCP625_SH +: Q625_W];
        r625_full   = time_reg[TIME_W-1:TLO_W] - (THI_W'(q625_reg) * THI_W'(DIV625));
        rem_next    = {r625_full[R625_W-1:0], time_reg[TLO_W-1:0]};
        s_prod      = SPROD_W'(rem_reg[REM_W-1:1]) * SPROD_W'(RCP125);
        quo_next    = s_prod[RCP125_SH +: SLOT_W];
        slot_fresh  = (quo_reg != last_reg);
        slot_zero   = (quo_reg == 7'd0);
        slot_mod20  = slot_zero || (quo_reg == 7'd20) || (quo_reg == 7'd40)
                      || (quo_reg == 7'd60);
        slot_mod8   = (quo_reg[2:0] == 3'd0);
        addr_dec    = (addr_reg == '0) ? LAST_SLOT_INDEX : (addr_reg - 7'd1);
        acc_entry   = rd_vld_reg ? rd_data_reg : '0;
        acc_sum     = acc_reg + SUM_W'(acc_entry);
        acc_cnt_inc = acc_cnt_reg + 7'd1;
        dec_hit     = (div_reg > DIV_MIN) && avg_at_most(s40_reg, dec_thr_reg, WIN_DEC);
        inc_hit     = (div_reg < DIV_MAX) && !avg_at_most(s8_reg, inc_thr_reg, WIN_INC);
        off_hit     = avg_at_most(acc_reg, off_thr_reg, WIN_OFF_SET);
        on_hit      = !avg_at_most(s32_reg, off_thr_reg, WIN_OFF_CLR);
        div_start   = cfg_wdata[DIV_W-1:0];
        if (div_start < DIV_MIN)
        begin
            div_start = DIV_MIN;
        end
        else if (div_start > DIV_MAX)
        begin
            div_start = DIV_MAX;
        end
    end

    always_comb
    begin
        sts.fresh      = slot_fresh;
        sts.slot_zero  = slot_zero;
        sts.slot_mod20 = slot_mod20;
        sts.slot_mod8  = slot_mod8;
        sts.out_busy   = out_vld_reg && !result.ready;
        priority if (slot_zero)
        begin
            sts.sweep_len = WIN_OFF_SET;
        end
        else if (slot_mod20)
        begin
            sts.sweep_len = WIN_DEC;
        end
        else if (slot_mod8)
        begin
            sts.sweep_len = WIN_OFF_CLR;
        end
        else
        begin
            sts.sweep_len = WIN_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_thr_reg <= DEC_THR_RESET;
            inc_thr_reg <= INC_THR_RESET;
            off_thr_reg <= OFF_THR_RESET;
            div_reg     <= DIV_RESET;
            off_reg     <= 1'b0;
            last_reg    <= LAST_SLOT_RESET;
            vld_reg     <= '0;
            rd_pend_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_DEC_THR:   dec_thr_reg <= cfg_wdata;
                    REG_INC_THR:   inc_thr_reg <= cfg_wdata;
                    REG_OFF_THR:   off_thr_reg <= cfg_wdata;
                    REG_DIV_START: div_reg     <= div_start;
                endcase
            end
            if (cmd.slot_cmp && slot_fresh)
            begin
                last_reg         <= quo_reg;
                vld_reg[quo_reg] <= 1'b1;
            end
            rd_pend_reg <= cmd.rd_issue;
            if (cmd.dec_chk && dec_hit)
            begin
                div_reg <= div_reg - 7'd1;
            end
            if (cmd.inc_chk && inc_hit)
            begin
                div_reg <= div_reg + 7'd1;
            end
            if (cmd.off_set_chk && off_hit)
            begin
                off_reg <= 1'b1;
            end
            if (cmd.off_clr_chk && on_hit)
            begin
                off_reg <= 1'b0;
            end
            out_vld_reg <= cmd.out_load || (out_vld_reg && !result.ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            time_reg  <= time_ms;
            level_reg <= level;
        end
        // two steps: the quotient by 625 settles first, the remainder second
        if (cmd.mod_step)
        begin
            q625_reg <= q625_next;
            rem_reg  <= rem_next;
        end
        if (cmd.quo_step)
        begin
            quo_reg <= quo_next;
        end
        if (cmd.slot_cmp)
        begin
            fresh_reg   <= slot_fresh;
            addr_reg    <= quo_reg;
            acc_reg     <= '0;
            acc_cnt_reg <= '0;
        end
        if (cmd.slot_cmp && slot_fresh)
        begin
            ring_mem[quo_reg] <= level_reg;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= ring_mem[addr_reg];
            rd_vld_reg  <= vld_reg[addr_reg];
            addr_reg    <= addr_dec;
        end
        if (rd_pend_reg)
        begin
            acc_reg     <= acc_sum;
            acc_cnt_reg <= acc_cnt_inc;
            if (acc_cnt_inc == WIN_INC)
            begin
                s8_reg <= acc_sum;
            end
            if (acc_cnt_inc == WIN_OFF_CLR)
            begin
                s32_reg <= acc_sum;
            end
            if (acc_cnt_inc == WIN_DEC)
            begin
                s40_reg <= acc_sum;
            end
        end
        if (cmd.out_load)
        begin
            out_new_reg  <= fresh_reg;
            out_slot_reg <= quo_reg;
            out_div_reg  <= div_reg;
            out_off_reg  <= off_reg;
        end
    end

    assign result.valid      = out_vld_reg;
    assign result.new_slot   = out_new_reg;
    assign result.slot_index = out_slot_reg;
    assign result.divider    = out_div_reg;
    assign result.is_off     = out_off_reg;

    `LGWC_ASSERT_ALWAYS(a_div_range, (div_reg >= DIV_MIN) && (div_reg <= DIV_MAX), "divider range")
    `LGWC_ASSERT_IMPL(a_rem_range, cmd.quo_step, rem_reg < MOD_PERIOD, "remainder out of range")
    `LGWC_ASSERT_IMPL(a_slot_math, cmd.slot_cmp, quo_reg <= LAST_SLOT_INDEX, "slot out of range")
    `LGWC_ASSERT_IMPL(a_out_free, cmd.out_load, !out_vld_reg || result.ready, "result lost")

endmodule

>>> hw/rtl/lgwc_ctrl.sv
// Controller: sequences slot arithmetic, ring sweep and the window checks
`include "loudness_gain_window_control_assert.svh"

module lgwc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  lgwc_pkg::lgwc_sts_t sts,
    output lgwc_pkg::lgwc_cmd_t cmd
);
    import lgwc_pkg::*;

    lgwc_state_t       state_reg;
    lgwc_state_t       state_next;
    logic [SLOT_W-1:0] cnt_reg;
    logic [SLOT_W-1:0] cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg + 7'd1;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_valid)
                begin
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (cnt_reg == MOD_LAST)
                begin
                    state_next = ST_QUO;
                    cnt_next   = '0;
                end
            end
            ST_QUO:
            begin
                if (cnt_reg == QUO_LAST)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                cnt_next = '0;
                if (sts.fresh && (sts.sweep_len != WIN_NONE))
                begin
                    state_next = ST_SWEEP;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_SWEEP:
            begin
                if (cnt_reg == (sts.sweep_len - 7'd1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                priority if (sts.slot_mod20)
                begin
                    state_next = ST_DEC;
                end
                else if (sts.slot_mod8)
                begin
                    state_next = ST_INC;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_DEC:
            begin
                state_next = sts.slot_mod8 ? ST_INC : ST_FIN;
            end
            ST_INC:
            begin
                state_next = sts.slot_zero ? ST_OFF_SET : ST_OFF_CLR;
            end
            ST_OFF_SET:
            begin
                state_next = ST_OFF_CLR;
            end
            ST_OFF_CLR:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!sts.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            ST_MOD:     cmd.mod_step    = 1'b1;
            ST_QUO:     cmd.quo_step    = 1'b1;
            ST_CMP:     cmd.slot_cmp    = 1'b1;
            ST_SWEEP:   cmd.rd_issue    = 1'b1;
            ST_DRAIN:   cmd             = '0;
            ST_DEC:     cmd.dec_chk     = 1'b1;
            ST_INC:     cmd.inc_chk     = 1'b1;
            ST_OFF_SET: cmd.off_set_chk = 1'b1;
            ST_OFF_CLR: cmd.off_clr_chk = 1'b1;
            ST_FIN:     cmd.out_load    = !sts.out_busy;
            default:    cmd             = '0;
        endcase
    end

    `LGWC_ASSERT_ALWAYS(a_cmd_single, $onehot0(cmd), "more than one datapath command")
    `LGWC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "taken while busy")
    `LGWC_ASSERT_IMPL(a_sweep_len, cmd.rd_issue, sts.sweep_len != WIN_NONE, "read without a window")

endmodule

>>> dv/loudness_gain_window_control_tb.sv
// Self-checking testbench for the loudness gain window control, with an independent predictor
`timescale 1ns / 100ps

module loudness_gain_window_control_tb;
    import lgwc_pkg::*;

    typedef struct packed {
        logic              new_slot;
        logic [SLOT_W-1:0] slot_index;
        logic [DIV_W-1:0]  divider;
        logic              is_off;
    } gain_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    lgwc_in_if  sample_ch ();
    lgwc_out_if result_ch ();

    loudness_gain_window_control uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    logic signed [LEVEL_W-1:0] level_hist [RING_DEPTH];
    logic [SLOT_W-1:0]         last_seen_slot;
    logic [DIV_W-1:0]          divider_now;
    logic                      off_now;
    int                        dec_limit;
    int                        inc_limit;
    int                        off_limit;

    gain_result_t pending_results [$];
    int           error_count;

    logic         stall_en;
    logic         gaps_en;
    logic         hold_off;
    int           stall_left;

    logic [TIME_W-1:0] stream_time;
    int                level_base;
    int                level_spread;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("loudness_gain_window_control_tb: errors");
        $finish;
    end

    // receiver: random stall bursts, plus a long hold-off on request
    initial
    begin
        result_ch.ready = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
                result_ch.ready <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else if (stall_en && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 2);
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (error_count < 40)
            $display("%0t  %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        gain_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result transfer with nothing pending, slot",
                                result_ch.slot_index, -1);
            else
            begin
                want = pending_results.pop_front();
                if (result_ch.new_slot !== want.new_slot)
                    report_mismatch("new_slot", result_ch.new_slot, want.new_slot);
                if (result_ch.slot_index !== want.slot_index)
                    report_mismatch("slot_index", result_ch.slot_index, want.slot_index);
                if (result_ch.divider !== want.divider)
                    report_mismatch("divider", result_ch.divider, want.divider);
                if (result_ch.is_off !== want.is_off)
                    report_mismatch("is_off", result_ch.is_off, want.is_off);
            end
        end
    end

    function automatic int clamp16(input int v);
        if (v < -32768)
            return -32768;
        if (v > 32767)
            return 32767;
        return v;
    endfunction

    function automatic int level_jitter(input int spread);
        return int'($urandom_range(0, 2 * spread)) - spread;
    endfunction

    function automatic int window_mean(input int unsigned slot, input int count);
        int acc;
        int i;
        acc = 0;
        for (i = 0; i < count; i++)
            acc += level_hist[(slot + RING_DEPTH - i) % RING_DEPTH];
        return acc / count;
    endfunction

    function automatic gain_result_t predict_gain_step(input logic [TIME_W-1:0] t,
                                                       input logic signed [LEVEL_W-1:0] lvl);
        int unsigned  slot;
        gain_result_t r;
        slot = ((t / 1000) % 20) * 4 + (t % 1000) / 250;
        r.new_slot = (slot != last_seen_slot);
        if (r.new_slot)
        begin
            last_seen_slot = slot[SLOT_W-1:0];
            level_hist[slot] = lvl;
            if (slot % 20 == 0 && window_mean(slot, WIN_DEC) <= dec_limit
                && divider_now > DIV_MIN)
                divider_now = divider_now - 1'b1;
            if (slot % 8 == 0 && window_mean(slot, WIN_INC) > inc_limit
                && divider_now < DIV_MAX)
                divider_now = divider_now + 1'b1;
            if (slot == 0 && window_mean(slot, WIN_OFF_SET) <= off_limit)
                off_now = 1'b1;
            if (slot % 8 == 0 && window_mean(slot, WIN_OFF_CLR) > off_limit)
                off_now = 1'b0;
        end
        r.slot_index = slot[SLOT_W-1:0];
        r.divider    = divider_now;
        r.is_off     = off_now;
        return r;
    endfunction

    task automatic send_sample(input logic [TIME_W-1:0] t, input logic [LEVEL_W-1:0] lvl);
        if (gaps_en && $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3))
            begin
                @(negedge clk);
                sample_ch.valid <= 1'b0;
            end
        @(negedge clk);
        sample_ch.valid   <= 1'b1;
        sample_ch.time_ms <= t;
        sample_ch.level   <= lvl;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        pending_results.push_back(predict_gain_step(t, lvl));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_DEC_THR:
                dec_limit = $signed(data);
            REG_INC_THR:
                inc_limit = $signed(data);
            REG_OFF_THR:
                off_limit = $signed(data);
            REG_DIV_START:
            begin
                if (data[DIV_W-1:0] < DIV_MIN)
                    divider_now = DIV_MIN;
                else if (data[DIV_W-1:0] > DIV_MAX)
                    divider_now = DIV_MAX;
                else
                    divider_now = data[DIV_W-1:0];
            end
        endcase
    endtask

    // drop valid, drain pending results, then let the block settle
    task automatic wait_for_idle;
        @(negedge clk);
        sample_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (130) @(posedge clk);
    endtask

    task automatic run_stream(input int count);
        int r;
        int k;
        logic [LEVEL_W-1:0] lvl;
        for (k = 0; k < count; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
                stream_time = $urandom;
            else if (r < 15)
                stream_time += $urandom_range(0, 120);
            else
                stream_time += $urandom_range(200, 300);
            if (k % 40 == 39)
                level_base = clamp16(level_base + level_jitter(2000));
            if ($urandom_range(0, 99) < 8)
                lvl = 16'($urandom);
            else
                lvl = 16'(clamp16(level_base + level_jitter(level_spread)));
            send_sample(stream_time, lvl);
        end
    endtask

    task automatic test_reset_defaults;
        send_sample(32'd12500, 16'sd0);
        send_sample(32'd0, 16'h8000);
        send_sample(32'd0, 16'sd5);
        send_sample(32'hFFFF_FFFF, 16'h7FFF);
    endtask

    task automatic test_field_extremes;
        send_sample(32'd19999, 16'h7FFF);
        send_sample(32'd2000, 16'h7FFF);
        send_sample(32'hAAAA_AAAA, 16'h5555);
        send_sample(32'h5555_5555, 16'hAAAA);
        send_sample(32'd5000, 16'hFFFF);
        send_sample(32'd10000, 16'h0001);
        send_sample(32'd15000, 16'h8000);
        send_sample(32'd16000, 16'h0000);
    endtask

    task automatic test_divider_limits;
        wait_for_idle;
        write_reg(REG_DIV_START, 16'd21);
        write_reg(REG_DEC_THR, 16'h7FFF);
        write_reg(REG_INC_THR, 16'h7FFF);
        send_sample(32'd20000, 16'sd0);
        send_sample(32'd5000, 16'sd0);
        wait_for_idle;
        write_reg(REG_DIV_START, 16'hFF77);
        write_reg(REG_INC_THR, 16'h8000);
        write_reg(REG_DEC_THR, 16'h8000);
        send_sample(32'd2000, 16'sd0);
        send_sample(32'd4000, 16'sd0);
        wait_for_idle;
        write_reg(REG_DIV_START, 16'd0);
        send_sample(32'd4250, 16'sd0);
        wait_for_idle;
        write_reg(REG_DIV_START, 16'h007F);
        send_sample(32'd4500, 16'sd0);
        wait_for_idle;
        write_reg(REG_OFF_THR, 16'h7FFF);
        send_sample(32'd40000, 16'sd0);
        wait_for_idle;
        write_reg(REG_OFF_THR, 16'h8000);
        send_sample(32'd42000, 16'sd0);
    endtask

    task automatic test_random_phases;
        int phase;
        int thr [3];
        int k;
        for (phase = 0; phase < 8; phase++)
        begin
            wait_for_idle;
            case (phase % 4)
                0: level_base = int'($urandom_range(0, 400)) - 200;
                1: level_base = int'($urandom_range(0, 65535)) - 32768;
                2: level_base = int'($urandom_range(20000, 32000));
                default: level_base = 0 - int'($urandom_range(20000, 32000));
            endcase
            case ($urandom_range(0, 3))
                0: level_spread = 30;
                1: level_spread = 300;
                2: level_spread = 3000;
                default: level_spread = 20000;
            endcase
            for (k = 0; k < 3; k++)
            begin
                if (phase == 5)
                    thr[k] = (k == 1) ? -32768 : 32767;
                else if (phase == 6)
                    thr[k] = (k == 1) ? 32767 : -32768;
                else
                    thr[k] = clamp16(level_base + level_jitter(level_spread));
            end
            write_reg(REG_DEC_THR, 16'(thr[0]));
            write_reg(REG_INC_THR, 16'(thr[1]));
            write_reg(REG_OFF_THR, 16'(thr[2]));
            if ($urandom_range(0, 1) == 0)
                write_reg(REG_DIV_START, {9'($urandom), 7'($urandom_range(20, 120))});
            else
                write_reg(REG_DIV_START, 16'($urandom));
            stall_en = (phase != 3);
            gaps_en  = (phase != 3);
            stream_time = $urandom;
            run_stream(120);
        end
    endtask

    task automatic test_result_backpressure;
        stall_en = 1'b1;
        gaps_en  = 1'b1;
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
        join_none
        run_stream(12);
    endtask

    task automatic test_back_to_back;
        stall_en = 1'b0;
        gaps_en  = 1'b0;
        run_stream(150);
    endtask

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = REG_DEC_THR;
        cfg_wdata         = '0;
        sample_ch.valid   = 1'b0;
        sample_ch.time_ms = '0;
        sample_ch.level   = '0;
        stall_en          = 1'b1;
        gaps_en           = 1'b1;
        hold_off          = 1'b0;
        error_count       = 0;
        foreach (level_hist[i])
            level_hist[i] = '0;
        last_seen_slot = LAST_SLOT_RESET;
        divider_now    = DIV_RESET;
        off_now        = 1'b0;
        dec_limit      = DEC_THR_RESET;
        inc_limit      = INC_THR_RESET;
        off_limit      = OFF_THR_RESET;
        stream_time    = '0;
        level_base     = 0;
        level_spread   = 300;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults;
        test_field_extremes;
        test_divider_limits;
        test_random_phases;
        test_result_backpressure;
        test_back_to_back;
        wait_for_idle;

        if (error_count == 0)
            $display("loudness_gain_window_control_tb: clean");
        else
            $display("loudness_gain_window_control_tb: errors");
        $finish;
    end

endmodule
